[hw/rtl/spq_pkg.sv]
// shared types, constants and codes for the sorted priority queue
`default_nettype none
package spq_pkg;

    localparam int NODE_COUNT_DEF = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int NODE_W         = 6;
    localparam int IN_KEY_W       = 32;
    localparam int COUNT_W        = 7;

    typedef enum logic [2:0] {
        OP_PUT    = 3'd0,
        OP_GET    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_MOVE   = 3'd3,
        OP_EXPIRE = 3'd4,
        OP_OFFSET = 3'd5,
        OP_QUERY  = 3'd6,
        OP_NOP    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NONE   = 2'd1,
        ST_DUP    = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_HEAD_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_INS_RD,
        S_INS_CHK,
        S_INS_SH_RD,
        S_INS_SH_WR,
        S_OFS_RD,
        S_OFS_WR,
        S_MV_PREV_RD,
        S_MV_PREV_CHK,
        S_MV_NEXT_RD,
        S_MV_NEXT_CHK,
        S_DONE_GATE
    } state_t;

    typedef struct packed {
        logic [2:0]                 opcode;
        logic [NODE_W-1:0]          node_id;
        logic signed [IN_KEY_W-1:0] key;
        logic signed [IN_KEY_W-1:0] delta;
        logic signed [IN_KEY_W-1:0] current_tick;
        logic                       key_kind;
    } in_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic [NODE_W-1:0]          node_out;
        logic signed [IN_KEY_W-1:0] key_out;
        logic [COUNT_W-1:0]         entry_count;
    } out_t;

endpackage
`default_nettype wire

[hw/rtl/spq_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

[hw/rtl/spq_alu.sv]
// shared key adder and signed compare unit
`default_nettype none
module spq_alu
    import spq_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic [KEY_BITS-1:0] a,
    input  wire logic [KEY_BITS-1:0] b,
    input  wire alu_op_t             op,
    output logic      [KEY_BITS-1:0] result,
    output logic                     le
);
    // add or subtract, wrapping
    assign result = (op == ALU_SUB) ? (a - b) : (a + b);
    // signed a <= b
    assign le = ($signed(a) <= $signed(b));
endmodule
`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// Sorted priority queue: node ids kept in a ram ordered by signed key, head first.
// Each command is taken only when the block is idle. Errors, no-ops and an offset on
// an empty list finish at once; the rest walk the list one entry at a time through the
// single registered read port of the list ram and one shared add/compare unit. Remove,
// move and key query first search for the node; get/expire and remove shift the tail
// down to close the gap, put searches for its place and shifts the tail up, and offset rewrites every entry.
// The result sits in an output register, so a new command is taken while it waits.
`default_nettype none
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);
    localparam int AW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int EW = KEY_BITS + NODE_W;

    state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, p_reg, p_next, cnt_reg, cnt_next;
    op_t op_reg, op_next;
    logic [NODE_W-1:0] nid_reg, nid_next, nout_reg, nout_next;
    logic [KEY_BITS-1:0] k_reg, k_next, d_reg, d_next, tick_reg, tick_next;
    logic kind_reg, kind_next, lo_ok_reg, lo_ok_next;
    status_t st_reg, st_next;
    logic [IN_KEY_W-1:0] kout_reg, kout_next;
    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;
    logic [NODE_COUNT-1:0] queued_reg;
    logic q_we, q_val;
    logic [AW-1:0] q_idx;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [KEY_BITS-1:0] rd_key;
    logic [NODE_W-1:0] rd_node;

    logic [KEY_BITS-1:0] alu_a, alu_b, alu_res;
    alu_op_t alu_op;
    logic alu_le;

    logic accept, in_valid_id, in_present, out_free;
    logic [CW:0] i_inc, p_inc;

    spq_ram #(.WIDTH(EW), .DEPTH(NODE_COUNT)) u_list (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    spq_alu #(.KEY_BITS(KEY_BITS)) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .op     (alu_op),
        .result (alu_res),
        .le     (alu_le)
    );

    assign rd_key  = ram_rdata[EW-1:NODE_W];
    assign rd_node = ram_rdata[NODE_W-1:0];
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign in_valid_id = ({1'b0, s_data.node_id} < (NODE_W + 1)'(NODE_COUNT))
                         || (NODE_COUNT > (1 << NODE_W));
    assign in_present  = in_valid_id && queued_reg[AW'(s_data.node_id)];
    assign i_inc = (CW + 1)'(i_reg) + 1'b1;
    assign p_inc = (CW + 1)'(p_reg) + 1'b1;

    // shared unit operand select
    always_comb begin
        alu_a  = rd_key;
        alu_b  = k_reg;
        alu_op = ALU_ADD;
        case (state_reg)
            S_FIND_CHK: begin
                alu_b  = tick_reg;
                alu_op = ALU_SUB;
            end
            S_HEAD_CHK: begin
                alu_b = tick_reg;
            end
            S_MV_NEXT_CHK: begin
                alu_a = k_reg;
                alu_b = rd_key;
            end
            S_OFS_WR: begin
                alu_b = d_reg;
            end
            default: begin
            end
        endcase
    end

    // sequencer: next state, list ram access and result
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        p_next       = p_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        nid_next     = nid_reg;
        k_next       = k_reg;
        d_next       = d_reg;
        tick_next    = tick_reg;
        kind_next    = kind_reg;
        lo_ok_next   = lo_ok_reg;
        st_next      = st_reg;
        nout_next    = nout_reg;
        kout_next    = kout_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_we         = 1'b0;
        q_val        = 1'b0;
        q_idx        = AW'(s_data.node_id);
        ram_we       = 1'b0;
        ram_waddr    = AW'(i_reg);
        ram_wdata    = ram_rdata;
        ram_raddr    = AW'(i_reg);

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next   = op_t'(s_data.opcode);
                    nid_next  = s_data.node_id;
                    k_next    = KEY_BITS'(s_data.key);
                    d_next    = KEY_BITS'(s_data.delta);
                    tick_next = KEY_BITS'(s_data.current_tick);
                    kind_next = s_data.key_kind;
                    st_next   = ST_OK;
                    nout_next = '0;
                    kout_next = '0;
                    i_next    = '0;
                    ram_raddr = '0;
                    // decode: errors, no-ops and an offset on an empty list finish at once, the rest walk the list
                    case (op_t'(s_data.opcode))
                        OP_PUT: begin
                            if (!in_valid_id) begin
                                st_next = ST_ABSENT;
                                state_next = S_DONE_GATE;
                            end else if (in_present) begin
                                st_next = ST_DUP;
                                state_next = S_DONE_GATE;
                            end else begin
                                q_we = 1'b1;
                                q_val = 1'b1;
                                state_next = S_INS_RD;
                            end
                        end
                        OP_GET, OP_EXPIRE: begin
                            if (cnt_reg == '0) begin
                                st_next = ST_NONE;
                                state_next = S_DONE_GATE;
                            end else begin
                                state_next = S_HEAD_CHK;
                            end
                        end
                        OP_REMOVE: begin
                            if (!in_present) begin
                                st_next = ST_ABSENT;
                                state_next = S_DONE_GATE;
                            end else begin
                                q_we = 1'b1;
                                state_next = S_FIND_RD;
                            end
                        end
                        OP_MOVE, OP_QUERY: begin
                            if (!in_present) begin
                                st_next = ST_ABSENT;
                                state_next = S_DONE_GATE;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                        OP_OFFSET: begin
                            state_next = (cnt_reg == '0) ? S_DONE_GATE : S_OFS_RD;
                        end
                        default: begin
                            state_next = S_DONE_GATE;
                        end
                    endcase
                end
            end
            S_FIND_RD: begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (rd_node == nid_reg) begin
                    p_next = i_reg;
                    case (op_reg)
                        OP_QUERY: begin
                            kout_next = IN_KEY_W'(kind_reg ? alu_res : rd_key);
                            state_next = S_DONE_GATE;
                        end
                        OP_MOVE: begin
                            state_next = S_MV_PREV_RD;
                        end
                        default: begin
                            state_next = S_DEL_RD;
                        end
                    endcase
                end else begin
                    i_next = CW'(i_inc);
                    state_next = S_FIND_RD;
                end
            end
            S_HEAD_CHK: begin
                if (op_reg == OP_EXPIRE && !alu_le) begin
                    st_next = ST_NONE;
                    state_next = S_DONE_GATE;
                end else begin
                    nout_next = rd_node;
                    kout_next = IN_KEY_W'(rd_key);
                    q_we = 1'b1;
                    q_idx = AW'(rd_node);
                    i_next = '0;
                    state_next = S_DEL_RD;
                end
            end
            // close the gap: entry i takes entry i+1
            S_DEL_RD: begin
                ram_raddr = AW'(i_inc);
                if (i_inc >= (CW + 1)'(cnt_reg)) begin
                    cnt_next = cnt_reg - 1'b1;
                    i_next = '0;
                    state_next = (op_reg == OP_MOVE) ? S_INS_RD : S_DONE_GATE;
                end else begin
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                ram_we = 1'b1;
                i_next = CW'(i_inc);
                state_next = S_DEL_RD;
            end
            // search for the first entry with a larger key
            S_INS_RD: begin
                if (i_reg >= cnt_reg) begin
                    p_next = i_reg;
                    i_next = cnt_reg;
                    state_next = S_INS_SH_RD;
                end else begin
                    state_next = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (alu_le) begin
                    i_next = CW'(i_inc);
                    state_next = S_INS_RD;
                end else begin
                    p_next = i_reg;
                    i_next = cnt_reg;
                    state_next = S_INS_SH_RD;
                end
            end
            // open a gap at p, moving the tail up one place
            S_INS_SH_RD: begin
                ram_raddr = AW'(i_reg - 1'b1);
                if (i_reg == p_reg) begin
                    ram_we = 1'b1;
                    ram_wdata = {k_reg, nid_reg};
                    cnt_next = cnt_reg + 1'b1;
                    state_next = S_DONE_GATE;
                end else begin
                    state_next = S_INS_SH_WR;
                end
            end
            S_INS_SH_WR: begin
                ram_we = 1'b1;
                i_next = i_reg - 1'b1;
                state_next = S_INS_SH_RD;
            end
            S_OFS_RD: begin
                state_next = S_OFS_WR;
            end
            S_OFS_WR: begin
                ram_we = 1'b1;
                ram_wdata = {alu_res, rd_node};
                i_next = CW'(i_inc);
                state_next = (i_inc >= (CW + 1)'(cnt_reg)) ? S_DONE_GATE : S_OFS_RD;
            end
            // move: check the key still fits between the neighbors
            S_MV_PREV_RD: begin
                ram_raddr = AW'(p_reg - 1'b1);
                if (p_reg == '0) begin
                    lo_ok_next = 1'b1;
                    state_next = S_MV_NEXT_RD;
                end else begin
                    state_next = S_MV_PREV_CHK;
                end
            end
            S_MV_PREV_CHK: begin
                lo_ok_next = alu_le;
                state_next = S_MV_NEXT_RD;
            end
            S_MV_NEXT_RD: begin
                ram_raddr = AW'(p_inc);
                ram_waddr = AW'(p_reg);
                ram_wdata = {k_reg, nid_reg};
                i_next = p_reg;
                if (p_inc >= (CW + 1)'(cnt_reg)) begin
                    ram_we = lo_ok_reg;
                    state_next = lo_ok_reg ? S_DONE_GATE : S_DEL_RD;
                end else begin
                    state_next = S_MV_NEXT_CHK;
                end
            end
            S_MV_NEXT_CHK: begin
                ram_waddr = AW'(p_reg);
                ram_wdata = {k_reg, nid_reg};
                i_next = p_reg;
                ram_we = lo_ok_reg && alu_le;
                state_next = (lo_ok_reg && alu_le) ? S_DONE_GATE : S_DEL_RD;
            end
            S_DONE_GATE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.status = st_reg;
                    m_data_next.node_out = nout_reg;
                    m_data_next.key_out = kout_reg;
                    m_data_next.entry_count = COUNT_W'(cnt_reg);
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            queued_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (q_we) begin
                queued_reg[q_idx] <= q_val;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        p_reg      <= p_next;
        op_reg     <= op_next;
        nid_reg    <= nid_next;
        k_reg      <= k_next;
        d_reg      <= d_next;
        tick_reg   <= tick_next;
        kind_reg   <= kind_next;
        lo_ok_reg  <= lo_ok_next;
        st_reg     <= st_next;
        nout_reg   <= nout_next;
        kout_reg   <= kout_next;
        m_data_reg <= m_data_next;
    end
endmodule
`default_nettype wire

[hw/rtl/spq_checker.sv]
// port level checks for the sorted priority queue, bound to the top level
`default_nettype none
module spq_checker
    import spq_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire in_t  s_data,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_t m_data
);
    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // a command never produces its result in the cycle after it is taken
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

    // failed commands return zero node and key
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.node_out == '0 && m_data.key_out == '0)
        else $error("error result carries data");

    // no more entries than the list holds
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entry_count <= COUNT_W'(NODE_COUNT_DEF))
        else $error("entry count out of range");
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
`default_nettype wire
